/* rtl/differential_drive_hbridge_ctrl_unit_macros.svh */
// assertion macros for the differential drive h-bridge controller checker
// no dependencies; included by the checker file
`ifndef DIFFERENTIAL_DRIVE_HBRIDGE_CTRL_UNIT_MACROS_SVH
`define DIFFERENTIAL_DRIVE_HBRIDGE_CTRL_UNIT_MACROS_SVH

// same-cycle implication
`define DDHB_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ddhb assertion failed");

// next-cycle implication
`define DDHB_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ddhb assertion failed");

`endif

/* rtl/ddhb_pkg.sv */
// shared types, codes and constants of the differential drive h-bridge controller
// no dependencies
package ddhb_pkg;

   localparam int DUTY_BITS_DEFAULT     = 8;
   localparam int DEFAULT_SPEED_DEFAULT = 50;

   localparam int OP_W       = 2;
   localparam int DIR_W      = 3;
   localparam int PCT_W      = 7;
   localparam int TICK_W     = 16;
   localparam int OUT_DUTY_W = 8;
   localparam int MOTION_W   = 4;
   localparam int REASON_W   = 3;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [PCT_W-1:0]      PCT_FULL      = 7'd100;
   localparam logic [PCT_W-1:0]      INNER_PCT     = 7'd40;
   localparam logic [PCT_W-1:0]      CAP_RESET     = 7'd100;
   localparam logic [TICK_W-1:0]     TIMEOUT_RESET = 16'd500;
   localparam logic [OUT_DUTY_W-1:0] OUT_DUTY_MAX  = 8'd255;
   localparam int                    INNER_PROD_W  = 14;

   // x / 100 as a reciprocal multiply, exact for x below 2^20
   localparam int              DIV_W       = 20;
   localparam logic [DIV_W-1:0] RECIP_100  = 20'd671089;
   localparam int              RECIP_SHIFT = 26;

   typedef enum logic [OP_W-1:0] {
      OP_DRIVE = 2'd0,
      OP_SPEED = 2'd1,
      OP_STOP  = 2'd2,
      OP_TICK  = 2'd3
   } op_type;

   typedef enum logic [DIR_W-1:0] {
      DIR_FWD       = 3'd0,
      DIR_BACK      = 3'd1,
      DIR_LEFT      = 3'd2,
      DIR_RIGHT     = 3'd3,
      DIR_FWD_LEFT  = 3'd4,
      DIR_FWD_RIGHT = 3'd5,
      DIR_BACK_LEFT = 3'd6,
      DIR_BACK_RIGHT = 3'd7
   } dir_type;

   typedef enum logic [REASON_W-1:0] {
      RSN_NONE          = 3'd0,
      RSN_SPEED_ZERO    = 3'd1,
      RSN_STOP_REQ      = 3'd2,
      RSN_INVALID_SPEED = 3'd3,
      RSN_CLIENT_LOST   = 3'd4,
      RSN_TIMEOUT       = 3'd5
   } reason_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_SAFETY_CAP = 1'd0,
      REG_TIMEOUT    = 1'd1
   } reg_idx_type;

   typedef enum logic [2:0] {
      DP_NONE     = 3'd0,
      DP_DIV_Q1   = 3'd1,
      DP_MUL_SPD  = 3'd2,
      DP_DIV_FULL = 3'd3,
      DP_MUL_IN   = 3'd4,
      DP_DIV_IN   = 3'd5
   } dp_op_type;

   typedef struct packed {
      logic      accept;
      dp_op_type op;
      logic      load_out;
   } dp_cmd_type;

   function automatic logic [DIV_W-1:0] div100(input logic [DIV_W-1:0] x);
      logic [2*DIV_W-1:0] p;
      p = {{DIV_W{1'b0}}, x} * {{DIV_W{1'b0}}, RECIP_100};
      return DIV_W'(p >> RECIP_SHIFT);
   endfunction

endpackage

/* rtl/ddhb_ifs.sv */
// channel interfaces of the differential drive h-bridge controller
// depends on ddhb_pkg
interface ddhb_req_if;
   logic                        valid;
   logic                        ready;
   logic [ddhb_pkg::OP_W-1:0]   operation;
   logic [ddhb_pkg::DIR_W-1:0]  direction;
   logic [ddhb_pkg::PCT_W-1:0]  speed_value;
   logic                        client_present;

   modport source (output valid, operation, direction, speed_value, client_present,
                   input ready);
   modport sink   (input valid, operation, direction, speed_value, client_present,
                   output ready);
endinterface

interface ddhb_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [ddhb_pkg::OUT_DUTY_W-1:0]   duty_a;
   logic [ddhb_pkg::OUT_DUTY_W-1:0]   duty_b;
   logic                              a_fwd;
   logic                              a_rev;
   logic                              b_fwd;
   logic                              b_rev;
   logic                              standby_n;
   logic [ddhb_pkg::MOTION_W-1:0]     motion_state;
   logic [ddhb_pkg::REASON_W-1:0]     stop_reason;

   modport source (output valid, duty_a, duty_b, a_fwd, a_rev, b_fwd, b_rev, standby_n,
                          motion_state, stop_reason,
                   input ready);
   modport sink   (input valid, duty_a, duty_b, a_fwd, a_rev, b_fwd, b_rev, standby_n,
                         motion_state, stop_reason,
                   output ready);
endinterface

interface ddhb_csr_if;
   logic                               valid;
   logic                               ready;
   logic [ddhb_pkg::CSR_IDX_W-1:0]     index;
   logic [ddhb_pkg::CSR_DATA_W-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/differential_drive_hbridge_ctrl_unit.sv */
// top level of the differential drive h-bridge controller
// depends on ddhb_pkg, ddhb_ifs, ddhb_ctrl and ddhb_datapath
//
// usage:
//   req_ch carries one command word: drive, set speed, stop request or tick.
//   rsp_ch returns exactly one result word per command: duties, bridge inputs,
//   standby line, motion state and the stop reason caused by that command.
//   csr_ch writes the duty cap (index 0) and the timeout (index 1); it is
//   always ready and a write takes effect at the next clock edge.
// sequencing:
//   a command is accepted in the idle state; the duty is then formed by one
//   shared multiply / reciprocal-divide step through ST_DIV1, ST_MUL_SPD,
//   ST_DIV2, ST_MUL_IN and ST_DIV_IN, the result is loaded in ST_DONE and a
//   new command is taken only after the controller returns to idle.
// reset:
//   synchronous; drive stopped, speed at DEFAULT_SPEED, tick count zero, cap
//   100 percent, timeout 500 ticks, no result pending.
// stalls:
//   a result held by rsp_ch.ready low stays stable in the result register; the
//   next command may be accepted and worked on, and waits at its end until the
//   register is emptied.
module differential_drive_hbridge_ctrl_unit #(
   parameter int DUTY_BITS     = ddhb_pkg::DUTY_BITS_DEFAULT,
   parameter int DEFAULT_SPEED = ddhb_pkg::DEFAULT_SPEED_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   ddhb_req_if.sink   req_ch,
   ddhb_rsp_if.source rsp_ch,
   ddhb_csr_if.sink   csr_ch
);

   ddhb_pkg::dp_cmd_type cmd;

   assign csr_ch.ready = 1'b1;

   ddhb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd)
   );

   ddhb_datapath #(
      .DUTY_BITS     (DUTY_BITS),
      .DEFAULT_SPEED (DEFAULT_SPEED)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .operation      (req_ch.operation),
      .direction      (req_ch.direction),
      .speed_value    (req_ch.speed_value),
      .client_present (req_ch.client_present),
      .csr_write      (csr_ch.valid),
      .csr_index      (csr_ch.index),
      .csr_data       (csr_ch.data),
      .duty_a         (rsp_ch.duty_a),
      .duty_b         (rsp_ch.duty_b),
      .a_fwd          (rsp_ch.a_fwd),
      .a_rev          (rsp_ch.a_rev),
      .b_fwd          (rsp_ch.b_fwd),
      .b_rev          (rsp_ch.b_rev),
      .standby_n      (rsp_ch.standby_n),
      .motion_state   (rsp_ch.motion_state),
      .stop_reason    (rsp_ch.stop_reason)
   );

endmodule

/* rtl/ddhb_datapath.sv */
// datapath: drive state, config registers, duty arithmetic and result register
// depends on ddhb_pkg; sequenced by ddhb_ctrl
module ddhb_datapath #(
   parameter int DUTY_BITS     = ddhb_pkg::DUTY_BITS_DEFAULT,
   parameter int DEFAULT_SPEED = ddhb_pkg::DEFAULT_SPEED_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  ddhb_pkg::dp_cmd_type                cmd,
   input  logic [ddhb_pkg::OP_W-1:0]           operation,
   input  logic [ddhb_pkg::DIR_W-1:0]          direction,
   input  logic [ddhb_pkg::PCT_W-1:0]          speed_value,
   input  logic                                client_present,
   input  logic                                csr_write,
   input  logic [ddhb_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ddhb_pkg::CSR_DATA_W-1:0]     csr_data,
   output logic [ddhb_pkg::OUT_DUTY_W-1:0]     duty_a,
   output logic [ddhb_pkg::OUT_DUTY_W-1:0]     duty_b,
   output logic                                a_fwd,
   output logic                                a_rev,
   output logic                                b_fwd,
   output logic                                b_rev,
   output logic                                standby_n,
   output logic [ddhb_pkg::MOTION_W-1:0]       motion_state,
   output logic [ddhb_pkg::REASON_W-1:0]       stop_reason
);

   localparam int ACC_W = (DUTY_BITS + ddhb_pkg::PCT_W > ddhb_pkg::INNER_PROD_W) ?
                          DUTY_BITS + ddhb_pkg::PCT_W : ddhb_pkg::INNER_PROD_W;
   localparam logic [DUTY_BITS-1:0] FULL = {DUTY_BITS{1'b1}};
   localparam int OW = ddhb_pkg::OUT_DUTY_W;

   logic [ddhb_pkg::PCT_W-1:0]    cap_ff, cap_in;
   logic [ddhb_pkg::TICK_W-1:0]   timeout_ff, timeout_in;
   logic [ddhb_pkg::MOTION_W-1:0] motion_ff, motion_in;
   logic [ddhb_pkg::PCT_W-1:0]    speed_ff, speed_in;
   logic [ddhb_pkg::TICK_W-1:0]   idle_ff, idle_in;
   ddhb_pkg::reason_type          reason_ff, reason_in;
   logic [ACC_W-1:0]              acc_ff, acc_in;
   logic [OW-1:0]                 full_ff, full_in;
   logic [OW-1:0]                 inner_ff, inner_in;

   logic [ddhb_pkg::PCT_W-1:0]    cap_lim;
   logic [ddhb_pkg::TICK_W-1:0]   idle_inc;
   logic [ddhb_pkg::DIV_W-1:0]    quot;

   logic [OW-1:0] duty_a_ff, duty_b_ff;
   logic          a_fwd_ff, a_rev_ff, b_fwd_ff, b_rev_ff, standby_n_ff;
   logic [ddhb_pkg::MOTION_W-1:0] motion_out_ff;
   logic [ddhb_pkg::REASON_W-1:0] reason_out_ff;
   logic [OW-1:0] duty_a_in, duty_b_in;
   logic          a_fwd_in, a_rev_in, b_fwd_in, b_rev_in, standby_n_in;
   ddhb_pkg::dir_type             d;

   // config registers
   always_comb begin
      cap_in     = cap_ff;
      timeout_in = timeout_ff;
      if (csr_write) begin
         unique case (ddhb_pkg::reg_idx_type'(csr_index))
            ddhb_pkg::REG_SAFETY_CAP: cap_in     = csr_data[ddhb_pkg::PCT_W-1:0];
            ddhb_pkg::REG_TIMEOUT:    timeout_in = csr_data[ddhb_pkg::TICK_W-1:0];
            default:                  cap_in     = cap_ff;
         endcase
      end
   end

   assign cap_lim  = (cap_ff > ddhb_pkg::PCT_FULL) ? ddhb_pkg::PCT_FULL : cap_ff;
   assign idle_inc = (idle_ff != {ddhb_pkg::TICK_W{1'b1}}) ? idle_ff + 16'd1 : idle_ff;
   assign quot     = ddhb_pkg::div100(ddhb_pkg::DIV_W'(acc_ff));

   // command decode and state update
   always_comb begin
      motion_in = motion_ff;
      speed_in  = speed_ff;
      idle_in   = idle_ff;
      reason_in = reason_ff;
      if (cmd.accept) begin
         reason_in = ddhb_pkg::RSN_NONE;
         unique case (ddhb_pkg::op_type'(operation))
            ddhb_pkg::OP_DRIVE: begin
               if (speed_ff == '0) begin
                  motion_in = '0;
                  reason_in = ddhb_pkg::RSN_SPEED_ZERO;
               end else begin
                  motion_in = ddhb_pkg::MOTION_W'(direction) + 4'd1;
                  idle_in   = '0;
               end
            end
            ddhb_pkg::OP_SPEED: begin
               if (speed_value > ddhb_pkg::PCT_FULL) begin
                  motion_in = '0;
                  reason_in = ddhb_pkg::RSN_INVALID_SPEED;
               end else begin
                  speed_in = speed_value;
                  if (speed_value == '0) begin
                     motion_in = '0;
                     reason_in = ddhb_pkg::RSN_SPEED_ZERO;
                  end else if (motion_ff != '0) begin
                     idle_in = '0;
                  end
               end
            end
            ddhb_pkg::OP_STOP: begin
               motion_in = '0;
               reason_in = ddhb_pkg::RSN_STOP_REQ;
            end
            ddhb_pkg::OP_TICK: begin
               idle_in = idle_inc;
               if (motion_ff != '0) begin
                  if (!client_present) begin
                     motion_in = '0;
                     reason_in = ddhb_pkg::RSN_CLIENT_LOST;
                  end else if (idle_inc > timeout_ff) begin
                     motion_in = '0;
                     reason_in = ddhb_pkg::RSN_TIMEOUT;
                  end
               end
            end
            default: motion_in = motion_ff;
         endcase
      end
   end

   // shared multiply / reciprocal-divide step
   always_comb begin
      acc_in   = acc_ff;
      full_in  = full_ff;
      inner_in = inner_ff;
      if (cmd.accept) begin
         acc_in = ACC_W'(FULL) * ACC_W'(cap_lim);
      end else begin
         case (cmd.op)
            ddhb_pkg::DP_DIV_Q1:   acc_in = ACC_W'(quot);
            ddhb_pkg::DP_MUL_SPD:  acc_in = acc_ff * ACC_W'(speed_ff);
            ddhb_pkg::DP_DIV_FULL: full_in = (quot > ddhb_pkg::DIV_W'(ddhb_pkg::OUT_DUTY_MAX)) ?
                                             ddhb_pkg::OUT_DUTY_MAX : quot[OW-1:0];
            ddhb_pkg::DP_MUL_IN:   acc_in = ACC_W'(full_ff) * ACC_W'(ddhb_pkg::INNER_PCT);
            ddhb_pkg::DP_DIV_IN:   inner_in = quot[OW-1:0];
            default:               acc_in = acc_ff;
         endcase
      end
   end

   // bridge decode
   always_comb begin
      d            = ddhb_pkg::dir_type'(ddhb_pkg::DIR_W'(motion_ff - 4'd1));
      duty_a_in    = '0;
      duty_b_in    = '0;
      a_fwd_in     = 1'b0;
      a_rev_in     = 1'b0;
      b_fwd_in     = 1'b0;
      b_rev_in     = 1'b0;
      standby_n_in = 1'b0;
      if (motion_ff != '0) begin
         standby_n_in = 1'b1;
         duty_a_in    = full_ff;
         duty_b_in    = full_ff;
         unique case (d)
            ddhb_pkg::DIR_FWD:        begin a_fwd_in = 1'b1; b_fwd_in = 1'b1; end
            ddhb_pkg::DIR_BACK:       begin a_rev_in = 1'b1; b_rev_in = 1'b1; end
            ddhb_pkg::DIR_LEFT:       begin a_rev_in = 1'b1; b_fwd_in = 1'b1; end
            ddhb_pkg::DIR_RIGHT:      begin a_fwd_in = 1'b1; b_rev_in = 1'b1; end
            ddhb_pkg::DIR_FWD_LEFT: begin
               a_fwd_in = 1'b1; b_fwd_in = 1'b1; duty_a_in = inner_ff;
            end
            ddhb_pkg::DIR_FWD_RIGHT: begin
               a_fwd_in = 1'b1; b_fwd_in = 1'b1; duty_b_in = inner_ff;
            end
            ddhb_pkg::DIR_BACK_LEFT: begin
               a_rev_in = 1'b1; b_rev_in = 1'b1; duty_a_in = inner_ff;
            end
            ddhb_pkg::DIR_BACK_RIGHT: begin
               a_rev_in = 1'b1; b_rev_in = 1'b1; duty_b_in = inner_ff;
            end
            default: standby_n_in = 1'b1;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff     <= ddhb_pkg::CAP_RESET;
         timeout_ff <= ddhb_pkg::TIMEOUT_RESET;
         motion_ff  <= '0;
         speed_ff   <= ddhb_pkg::PCT_W'(DEFAULT_SPEED);
         idle_ff    <= '0;
         reason_ff  <= ddhb_pkg::RSN_NONE;
      end else begin
         cap_ff     <= cap_in;
         timeout_ff <= timeout_in;
         motion_ff  <= motion_in;
         speed_ff   <= speed_in;
         idle_ff    <= idle_in;
         reason_ff  <= reason_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff   <= acc_in;
      full_ff  <= full_in;
      inner_ff <= inner_in;
      if (cmd.load_out) begin
         duty_a_ff     <= duty_a_in;
         duty_b_ff     <= duty_b_in;
         a_fwd_ff      <= a_fwd_in;
         a_rev_ff      <= a_rev_in;
         b_fwd_ff      <= b_fwd_in;
         b_rev_ff      <= b_rev_in;
         standby_n_ff  <= standby_n_in;
         motion_out_ff <= motion_ff;
         reason_out_ff <= reason_ff;
      end
   end

   assign duty_a       = duty_a_ff;
   assign duty_b       = duty_b_ff;
   assign a_fwd        = a_fwd_ff;
   assign a_rev        = a_rev_ff;
   assign b_fwd        = b_fwd_ff;
   assign b_rev        = b_rev_ff;
   assign standby_n    = standby_n_ff;
   assign motion_state = motion_out_ff;
   assign stop_reason  = reason_out_ff;

endmodule

/* rtl/ddhb_ctrl.sv */
// controller: sequences the datapath steps and owns the request and result handshakes
// depends on ddhb_pkg; drives ddhb_datapath by command
module ddhb_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output ddhb_pkg::dp_cmd_type cmd
);

   typedef enum logic [6:0] {
      ST_IDLE    = 7'b0000001,
      ST_DIV1    = 7'b0000010,
      ST_MUL_SPD = 7'b0000100,
      ST_DIV2    = 7'b0001000,
      ST_MUL_IN  = 7'b0010000,
      ST_DIV_IN  = 7'b0100000,
      ST_DONE    = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      cmd.accept   = 1'b0;
      cmd.op       = ddhb_pkg::DP_NONE;
      cmd.load_out = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_DIV1;
            end
         end
         ST_DIV1: begin
            cmd.op   = ddhb_pkg::DP_DIV_Q1;
            state_in = ST_MUL_SPD;
         end
         ST_MUL_SPD: begin
            cmd.op   = ddhb_pkg::DP_MUL_SPD;
            state_in = ST_DIV2;
         end
         ST_DIV2: begin
            cmd.op   = ddhb_pkg::DP_DIV_FULL;
            state_in = ST_MUL_IN;
         end
         ST_MUL_IN: begin
            cmd.op   = ddhb_pkg::DP_MUL_IN;
            state_in = ST_DIV_IN;
         end
         ST_DIV_IN: begin
            cmd.op   = ddhb_pkg::DP_DIV_IN;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // result register free or being emptied this cycle
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = cmd.load_out ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

/* rtl/ddhb_checker.sv */
// port-level checker for the differential drive h-bridge controller, with its bind
// depends on ddhb_pkg and differential_drive_hbridge_ctrl_unit_macros.svh
`include "differential_drive_hbridge_ctrl_unit_macros.svh"

module ddhb_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [ddhb_pkg::OUT_DUTY_W-1:0]     duty_a,
   input logic [ddhb_pkg::OUT_DUTY_W-1:0]     duty_b,
   input logic                                a_fwd,
   input logic                                a_rev,
   input logic                                b_fwd,
   input logic                                b_rev,
   input logic                                standby_n,
   input logic [ddhb_pkg::MOTION_W-1:0]       motion_state,
   input logic [ddhb_pkg::REASON_W-1:0]       stop_reason
);

   `DDHB_ASSERT_NXT(rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(duty_a) && $stable(duty_b) && $stable(motion_state) && $stable(stop_reason))
   `DDHB_ASSERT_IMP(standby_quiet, clock, reset, rsp_valid && !standby_n, !a_fwd && !a_rev && !b_fwd && !b_rev && duty_a == '0 && duty_b == '0)
   `DDHB_ASSERT_IMP(moving_sane, clock, reset, rsp_valid && standby_n, motion_state != '0 && stop_reason == '0 && (a_fwd != a_rev) && (b_fwd != b_rev))
   `DDHB_ASSERT_IMP(stop_means_stopped, clock, reset, rsp_valid && stop_reason != '0, motion_state == '0 && !standby_n)

endmodule

bind differential_drive_hbridge_ctrl_unit ddhb_checker u_ddhb_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .duty_a       (rsp_ch.duty_a),
   .duty_b       (rsp_ch.duty_b),
   .a_fwd        (rsp_ch.a_fwd),
   .a_rev        (rsp_ch.a_rev),
   .b_fwd        (rsp_ch.b_fwd),
   .b_rev        (rsp_ch.b_rev),
   .standby_n    (rsp_ch.standby_n),
   .motion_state (rsp_ch.motion_state),
   .stop_reason  (rsp_ch.stop_reason)
);

/* tb/sv/tb_differential_drive_hbridge_ctrl_unit.sv */
`timescale 1ns / 1ps
// self-checking testbench of the differential drive h-bridge controller
// predicts every result word from its own copy of the drive state and registers
// depends on ddhb_pkg, ddhb_ifs and differential_drive_hbridge_ctrl_unit
module tb_differential_drive_hbridge_ctrl_unit;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int PHASE_ITEMS    = 178;
   localparam int SOAK_TICKS     = 8;

   typedef struct {
      logic [ddhb_pkg::OUT_DUTY_W-1:0] duty_a;
      logic [ddhb_pkg::OUT_DUTY_W-1:0] duty_b;
      logic                            a_fwd;
      logic                            a_rev;
      logic                            b_fwd;
      logic                            b_rev;
      logic                            standby_n;
      logic [ddhb_pkg::MOTION_W-1:0]   motion_state;
      logic [ddhb_pkg::REASON_W-1:0]   stop_reason;
   } bridge_word_type;

   class drive_tracker;
      logic [ddhb_pkg::MOTION_W-1:0] motion;
      logic [ddhb_pkg::PCT_W-1:0]    speed;
      int unsigned                   idle_ticks;
      logic [ddhb_pkg::PCT_W-1:0]    cap;
      logic [ddhb_pkg::TICK_W-1:0]   timeout;
      bridge_word_type               expected_words[$];
      int                            mismatches;

      function new();
         motion     = '0;
         speed      = ddhb_pkg::PCT_W'(ddhb_pkg::DEFAULT_SPEED_DEFAULT);
         idle_ticks = 0;
         cap        = ddhb_pkg::CAP_RESET;
         timeout    = ddhb_pkg::TIMEOUT_RESET;
         mismatches = 0;
      endfunction

      function void write_register(ddhb_pkg::reg_idx_type idx,
                                   logic [ddhb_pkg::CSR_DATA_W-1:0] data);
         if (idx == ddhb_pkg::REG_SAFETY_CAP)
            cap = data[ddhb_pkg::PCT_W-1:0];
         else
            timeout = data[ddhb_pkg::TICK_W-1:0];
      endfunction

      function int unsigned full_duty();
         int unsigned scale, cap_eff, d;
         scale   = (1 << ddhb_pkg::DUTY_BITS_DEFAULT) - 1;
         cap_eff = (cap > ddhb_pkg::PCT_FULL) ? ddhb_pkg::PCT_FULL : cap;
         d       = (scale * cap_eff / ddhb_pkg::PCT_FULL) * speed / ddhb_pkg::PCT_FULL;
         return (d > ddhb_pkg::OUT_DUTY_MAX) ? ddhb_pkg::OUT_DUTY_MAX : d;
      endfunction

      function void note_command(ddhb_pkg::op_type op, ddhb_pkg::dir_type dir,
                                 logic [ddhb_pkg::PCT_W-1:0] spd, logic client);
         bridge_word_type      w;
         ddhb_pkg::reason_type why;
         int unsigned          full, inner;
         why = ddhb_pkg::RSN_NONE;
         case (op)
            ddhb_pkg::OP_DRIVE: begin
               if (speed == 0) begin
                  motion = '0;
                  why    = ddhb_pkg::RSN_SPEED_ZERO;
               end else begin
                  motion     = {1'b0, dir} + 4'd1;
                  idle_ticks = 0;
               end
            end
            ddhb_pkg::OP_SPEED: begin
               if (spd > ddhb_pkg::PCT_FULL) begin
                  motion = '0;
                  why    = ddhb_pkg::RSN_INVALID_SPEED;
               end else begin
                  speed = spd;
                  if (speed == 0) begin
                     motion = '0;
                     why    = ddhb_pkg::RSN_SPEED_ZERO;
                  end else if (motion != 0) begin
                     idle_ticks = 0;
                  end
               end
            end
            ddhb_pkg::OP_STOP: begin
               motion = '0;
               why    = ddhb_pkg::RSN_STOP_REQ;
            end
            default: begin
               if (idle_ticks < 65535)
                  idle_ticks++;
               if (motion != 0) begin
                  if (!client) begin
                     motion = '0;
                     why    = ddhb_pkg::RSN_CLIENT_LOST;
                  end else if (idle_ticks > timeout) begin
                     motion = '0;
                     why    = ddhb_pkg::RSN_TIMEOUT;
                  end
               end
            end
         endcase
         w.duty_a    = '0;
         w.duty_b    = '0;
         w.a_fwd     = 1'b0;
         w.a_rev     = 1'b0;
         w.b_fwd     = 1'b0;
         w.b_rev     = 1'b0;
         w.standby_n = 1'b0;
         if (motion != 0) begin
            full        = full_duty();
            inner       = full * ddhb_pkg::INNER_PCT / ddhb_pkg::PCT_FULL;
            w.duty_a    = ddhb_pkg::OUT_DUTY_W'(full);
            w.duty_b    = ddhb_pkg::OUT_DUTY_W'(full);
            w.standby_n = 1'b1;
            case (ddhb_pkg::dir_type'(ddhb_pkg::DIR_W'(motion - 4'd1)))
               ddhb_pkg::DIR_FWD: begin
                  w.a_fwd = 1'b1;
                  w.b_fwd = 1'b1;
               end
               ddhb_pkg::DIR_BACK: begin
                  w.a_rev = 1'b1;
                  w.b_rev = 1'b1;
               end
               ddhb_pkg::DIR_LEFT: begin
                  w.a_rev = 1'b1;
                  w.b_fwd = 1'b1;
               end
               ddhb_pkg::DIR_RIGHT: begin
                  w.a_fwd = 1'b1;
                  w.b_rev = 1'b1;
               end
               ddhb_pkg::DIR_FWD_LEFT: begin
                  w.a_fwd  = 1'b1;
                  w.b_fwd  = 1'b1;
                  w.duty_a = ddhb_pkg::OUT_DUTY_W'(inner);
               end
               ddhb_pkg::DIR_FWD_RIGHT: begin
                  w.a_fwd  = 1'b1;
                  w.b_fwd  = 1'b1;
                  w.duty_b = ddhb_pkg::OUT_DUTY_W'(inner);
               end
               ddhb_pkg::DIR_BACK_LEFT: begin
                  w.a_rev  = 1'b1;
                  w.b_rev  = 1'b1;
                  w.duty_a = ddhb_pkg::OUT_DUTY_W'(inner);
               end
               default: begin
                  w.a_rev  = 1'b1;
                  w.b_rev  = 1'b1;
                  w.duty_b = ddhb_pkg::OUT_DUTY_W'(inner);
               end
            endcase
         end
         w.motion_state = motion;
         w.stop_reason  = why;
         expected_words.push_back(w);
      endfunction

      function void check_result(bridge_word_type got);
         bridge_word_type want;
         if (expected_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: result word with nothing expected: %p", $realtime, got);
            return;
         end
         want = expected_words.pop_front();
         if (got.duty_a !== want.duty_a || got.duty_b !== want.duty_b ||
             got.a_fwd !== want.a_fwd || got.a_rev !== want.a_rev ||
             got.b_fwd !== want.b_fwd || got.b_rev !== want.b_rev ||
             got.standby_n !== want.standby_n ||
             got.motion_state !== want.motion_state ||
             got.stop_reason !== want.stop_reason) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: mismatch\n   expected %p\n   actual   %p",
                        $realtime, want, got);
         end
      endfunction

      function int pending();
         return expected_words.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   int   send_idle_pct;
   int   rsp_stall_pct;
   int   hold_left;
   int   quiet_cycles;

   ddhb_req_if req_ch ();
   ddhb_rsp_if rsp_ch ();
   ddhb_csr_if csr_ch ();

   drive_tracker tracker = new();

   differential_drive_hbridge_ctrl_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // receiver side: random stalls, or a long hold-off when asked
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_ch.ready = 1'b0;
         hold_left--;
      end else begin
         rsp_ch.ready = ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      bridge_word_type got;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.duty_a       = rsp_ch.duty_a;
            got.duty_b       = rsp_ch.duty_b;
            got.a_fwd        = rsp_ch.a_fwd;
            got.a_rev        = rsp_ch.a_rev;
            got.b_fwd        = rsp_ch.b_fwd;
            got.b_rev        = rsp_ch.b_rev;
            got.standby_n    = rsp_ch.standby_n;
            got.motion_state = rsp_ch.motion_state;
            got.stop_reason  = rsp_ch.stop_reason;
            tracker.check_result(got);
         end
         if (req_ch.valid && req_ch.ready)
            tracker.note_command(ddhb_pkg::op_type'(req_ch.operation),
                                 ddhb_pkg::dir_type'(req_ch.direction),
                                 req_ch.speed_value, req_ch.client_present);
         if (csr_ch.valid && csr_ch.ready)
            tracker.write_register(ddhb_pkg::reg_idx_type'(csr_ch.index), csr_ch.data);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", quiet_cycles);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   task automatic send_cmd(ddhb_pkg::op_type op, ddhb_pkg::dir_type dir,
                           logic [ddhb_pkg::PCT_W-1:0] spd, logic client);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         @(negedge clock);
         req_ch.valid = 1'b0;
      end
      @(negedge clock);
      req_ch.valid          = 1'b1;
      req_ch.operation      = op;
      req_ch.direction      = dir;
      req_ch.speed_value    = spd;
      req_ch.client_present = client;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
   endtask

   // mostly drive / speed / tick traffic with live clients, some stops and bad speeds
   task automatic send_random();
      int                         pick;
      ddhb_pkg::op_type           op;
      logic [ddhb_pkg::PCT_W-1:0] spd;
      logic                       client;
      pick   = $urandom_range(0, 99);
      spd    = ddhb_pkg::PCT_W'($urandom_range(0, 127));
      client = 1'($urandom_range(0, 1));
      if (pick < 30) begin
         op = ddhb_pkg::OP_DRIVE;
      end else if (pick < 50) begin
         op = ddhb_pkg::OP_SPEED;
         pick = $urandom_range(0, 99);
         if (pick < 6)
            spd = '0;
         else if (pick < 85)
            spd = ddhb_pkg::PCT_W'($urandom_range(1, 100));
         else
            spd = ddhb_pkg::PCT_W'($urandom_range(101, 127));
      end else if (pick < 55) begin
         op = ddhb_pkg::OP_STOP;
      end else begin
         op     = ddhb_pkg::OP_TICK;
         client = ($urandom_range(0, 99) < 92);
      end
      send_cmd(op, ddhb_pkg::dir_type'(ddhb_pkg::DIR_W'($urandom_range(0, 7))), spd, client);
   endtask

   task automatic settle();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (tracker.pending() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_reg(ddhb_pkg::reg_idx_type idx,
                            logic [ddhb_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_ch.valid = 1'b1;
      csr_ch.index = idx;
      csr_ch.data  = data;
      @(posedge clock);
      while (!csr_ch.ready)
         @(posedge clock);
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   task automatic run_phase(int sidle, int rstall, logic [ddhb_pkg::CSR_DATA_W-1:0] cap_word,
                            logic [ddhb_pkg::CSR_DATA_W-1:0] timeout_word, bit pressure);
      settle();
      write_reg(ddhb_pkg::REG_SAFETY_CAP, cap_word);
      write_reg(ddhb_pkg::REG_TIMEOUT, timeout_word);
      send_idle_pct = sidle;
      rsp_stall_pct = rstall;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
         if (pressure && i == PHASE_ITEMS / 3)
            hold_left = 300;
         if (pressure && i == 2 * PHASE_ITEMS / 3) begin
            @(negedge clock);
            req_ch.valid = 1'b0;
            while (tracker.pending() != 0)
               @(posedge clock);
         end
         send_random();
      end
   endtask

   initial begin
      reset                 = 1'b1;
      send_idle_pct         = 0;
      rsp_stall_pct         = 0;
      hold_left             = 0;
      quiet_cycles          = 0;
      req_ch.valid          = 1'b0;
      req_ch.operation      = ddhb_pkg::OP_DRIVE;
      req_ch.direction      = ddhb_pkg::DIR_FWD;
      req_ch.speed_value    = '0;
      req_ch.client_present = 1'b0;
      rsp_ch.ready          = 1'b0;
      csr_ch.valid          = 1'b0;
      csr_ch.index          = ddhb_pkg::REG_SAFETY_CAP;
      csr_ch.data           = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: every direction, speed edge values, stop reasons
      send_cmd(ddhb_pkg::OP_TICK, ddhb_pkg::DIR_FWD, 7'd0, 1'b1);
      for (int d = 0; d < 8; d++)
         send_cmd(ddhb_pkg::OP_DRIVE, ddhb_pkg::dir_type'(ddhb_pkg::DIR_W'(d)), 7'd0, 1'b0);
      send_cmd(ddhb_pkg::OP_SPEED, ddhb_pkg::DIR_FWD, 7'd100, 1'b1);
      send_cmd(ddhb_pkg::OP_SPEED, ddhb_pkg::DIR_BACK, 7'd127, 1'b0);
      send_cmd(ddhb_pkg::OP_SPEED, ddhb_pkg::DIR_BACK, 7'd101, 1'b0);
      send_cmd(ddhb_pkg::OP_SPEED, ddhb_pkg::DIR_LEFT, 7'd0, 1'b0);
      send_cmd(ddhb_pkg::OP_DRIVE, ddhb_pkg::DIR_FWD, 7'd127, 1'b1);
      send_cmd(ddhb_pkg::OP_SPEED, ddhb_pkg::DIR_LEFT, 7'd1, 1'b0);
      send_cmd(ddhb_pkg::OP_DRIVE, ddhb_pkg::DIR_BACK_LEFT, 7'd0, 1'b0);
      send_cmd(ddhb_pkg::OP_TICK, ddhb_pkg::DIR_BACK_RIGHT, 7'd127, 1'b0);
      send_cmd(ddhb_pkg::OP_TICK, ddhb_pkg::DIR_FWD, 7'd0, 1'b0);
      send_cmd(ddhb_pkg::OP_STOP, ddhb_pkg::DIR_FWD, 7'd0, 1'b0);
      send_cmd(ddhb_pkg::OP_SPEED, ddhb_pkg::DIR_FWD, 7'd77, 1'b0);
      send_cmd(ddhb_pkg::OP_DRIVE, ddhb_pkg::DIR_FWD_RIGHT, 7'd0, 1'b0);
      send_cmd(ddhb_pkg::OP_STOP, ddhb_pkg::DIR_FWD, 7'd0, 1'b0);

      settle();
      write_reg(ddhb_pkg::REG_TIMEOUT, 16'd1);
      write_reg(ddhb_pkg::REG_SAFETY_CAP, 16'hFF7F);
      send_cmd(ddhb_pkg::OP_DRIVE, ddhb_pkg::DIR_RIGHT, 7'd0, 1'b0);
      send_cmd(ddhb_pkg::OP_TICK, ddhb_pkg::DIR_FWD, 7'd0, 1'b1);
      send_cmd(ddhb_pkg::OP_TICK, ddhb_pkg::DIR_FWD, 7'd0, 1'b1);

      settle();
      write_reg(ddhb_pkg::REG_SAFETY_CAP, 16'd0);
      send_cmd(ddhb_pkg::OP_DRIVE, ddhb_pkg::DIR_FWD, 7'd0, 1'b1);

      // ticks with a timeout that never expires
      settle();
      write_reg(ddhb_pkg::REG_SAFETY_CAP, 16'd100);
      write_reg(ddhb_pkg::REG_TIMEOUT, 16'hFFFF);
      send_cmd(ddhb_pkg::OP_DRIVE, ddhb_pkg::DIR_FWD_LEFT, 7'd0, 1'b1);
      for (int i = 0; i < SOAK_TICKS; i++)
         send_cmd(ddhb_pkg::OP_TICK, ddhb_pkg::dir_type'(ddhb_pkg::DIR_W'($urandom_range(0, 7))),
                  ddhb_pkg::PCT_W'($urandom_range(0, 127)), 1'b1);
      send_cmd(ddhb_pkg::OP_TICK, ddhb_pkg::DIR_FWD, 7'd0, 1'b0);

      run_phase(0, 0, 16'd100, 16'hFFFF, 1'b1);
      run_phase(64, 0, ddhb_pkg::CSR_DATA_W'($urandom_range(1, 99)),
                ddhb_pkg::CSR_DATA_W'($urandom_range(1, 12)), 1'b0);
      run_phase(0, 64, 16'd127, 16'd1, 1'b0);
      run_phase(37, 37, ddhb_pkg::CSR_DATA_W'($urandom_range(0, 65535)),
                ddhb_pkg::CSR_DATA_W'($urandom_range(2, 8)), 1'b0);

      settle();
      repeat (20) @(posedge clock);
      if (tracker.pending() != 0)
         tracker.mismatches++;
      if (tracker.mismatches == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

/* files.f */
+incdir+rtl
rtl/ddhb_pkg.sv
rtl/ddhb_ifs.sv
rtl/ddhb_datapath.sv
rtl/ddhb_ctrl.sv
rtl/differential_drive_hbridge_ctrl_unit.sv
rtl/ddhb_checker.sv
tb/sv/tb_differential_drive_hbridge_ctrl_unit.sv
